FILE: src/kbd_pkg.sv
// Shared definitions for the scancode-to-ASCII keyboard FIFO.
// Holds operation codes, set-1 key codes, ASCII constants, the key tables and the
// structs passed between the key mapper, the FIFO and the top level. No dependencies.
package kbd_pkg;

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [6:0] SC_ESC       = 7'h01;
    localparam logic [6:0] SC_BACKSPACE = 7'h0E;
    localparam logic [6:0] SC_TAB       = 7'h0F;
    localparam logic [6:0] SC_ENTER     = 7'h1C;
    localparam logic [6:0] SC_LCTRL     = 7'h1D;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_LALT      = 7'h38;
    localparam logic [6:0] SC_CAPS      = 7'h3A;

    localparam logic [6:0] ASCII_NL   = 7'h0A;
    localparam logic [6:0] ASCII_BS   = 7'h08;
    localparam logic [6:0] ASCII_NONE = 7'h00;
    localparam logic [6:0] ASCII_CASE = 7'h20;

    // Width of the fill level reported on the master side, whatever the buffer depth.
    localparam int FILL_W = 9;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    typedef struct packed {
        logic       push;
        logic [6:0] ch;
    } key_evt_t;

    // Unshifted key table; codes without an entry give zero.
    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
            7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
            7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;
            7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;  7'h39: ch = 7'h20;
            default: ch = ASCII_NONE;
        endcase
        return ch;
    endfunction

    // Shifted key table; codes without an entry give zero.
    function automatic logic [6:0] upper_char(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
            7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;
            7'h13: ch = 7'h52;  7'h14: ch = 7'h54;  7'h15: ch = 7'h59;
            7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
            7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;
            7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;
            7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;
            7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
            7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;
            7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;  7'h39: ch = 7'h20;
            default: ch = ASCII_NONE;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/kbd_keymap.sv
// Scancode decoder: modifier and caps lock flags, and the mapping of make codes to ASCII.
// Depends on kbd_pkg for key codes, key tables and the flag and event structs.
module kbd_keymap (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              scan_en,
    input  logic [7:0]        scan_byte,
    output kbd_pkg::key_evt_t evt,
    output kbd_pkg::mod_flags_t flags_next
);
    import kbd_pkg::*;

    mod_flags_t flags_reg;
    logic       released;
    logic [6:0] code;
    logic [6:0] mapped;

    assign released = scan_byte[7];
    assign code     = scan_byte[6:0];

    always_comb
    begin
        mapped = flags_reg.shift ? upper_char(code) : plain_char(code);
        // Caps lock swaps letter case after the shift table has been applied.
        if (flags_reg.caps)
        begin
            if (mapped inside {[7'h61:7'h7A]})
                mapped = mapped - ASCII_CASE;
            else if (mapped inside {[7'h41:7'h5A]})
                mapped = mapped + ASCII_CASE;
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        evt.push   = 1'b0;
        evt.ch     = ASCII_NONE;
        if (scan_en)
        begin
            case (code)
                SC_LSHIFT, SC_RSHIFT: flags_next.shift = !released;
                SC_LCTRL:             flags_next.ctrl  = !released;
                SC_LALT:              flags_next.alt   = !released;
                SC_CAPS:
                begin
                    if (!released)
                        flags_next.caps = !flags_reg.caps;
                end
                SC_ENTER:
                begin
                    evt.push = !released;
                    evt.ch   = ASCII_NL;
                end
                SC_BACKSPACE:
                begin
                    evt.push = !released;
                    evt.ch   = ASCII_BS;
                end
                SC_ESC, SC_TAB:
                begin
                    evt.push = 1'b0;
                end
                default:
                begin
                    evt.push = !released && (mapped != ASCII_NONE);
                    evt.ch   = mapped;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

endmodule

FILE: src/kbd_fifo.sv
// Character ring buffer: one synchronous memory with registered read data,
// read and write pointers and a fill count. Depends on kbd_pkg for the event struct.
module kbd_fifo #(
    parameter int FIFO_DEPTH = 256,
    parameter int CNT_W      = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kbd_pkg::key_evt_t evt,
    input  logic              pop,
    input  logic              clear,
    output logic              pop_hit,
    output logic [CNT_W-1:0]  count_next,
    output logic [6:0]        rd_data
);
    import kbd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [6:0]       mem [FIFO_DEPTH];
    logic [6:0]       rd_data_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             wr_en;

    // A push and a pop never come in the same transfer, so an entry written in one
    // cycle is already in the memory when a following pop reads it.
    assign wr_en   = evt.push && (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_hit = pop && (count_reg != '0);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            count_next  = '0;
        end
        else if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop_hit)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= evt.ch;
        if (pop_hit)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign rd_data = rd_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fill count above depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        pop_hit && !clear |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not lower the fill count");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !clear |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not raise the fill count");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty buffer with unequal pointers");

endmodule

FILE: src/scancode_to_ascii_keyboard_fifo.sv
// Keyboard front end: set-1 scancodes in, ASCII characters buffered and popped out.
// One transfer is taken every cycle unless the input side stalls; its result appears
// on the master side in the next cycle, read from the character memory's single
// registered read port. Every input transfer gives exactly one output transfer carrying
// the popped character (zero when none), buffer status and the modifier and caps lock
// flags as they stand after it. The input side stalls only while a result waits unread.
// Depends on kbd_pkg, kbd_keymap and kbd_fifo.
module scancode_to_ascii_keyboard_fifo #(
    parameter int FIFO_DEPTH = 256,
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1),
    localparam int M_W       = ((13 + kbd_pkg::FILL_W + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // scan_byte[7:0]
    input  logic [1:0]     s_tuser,   // operation[1:0]
    output logic           m_tvalid,
    input  logic           m_tready,
    // char_out[6:0], char_valid, has_input, fill_level, shift_down, ctrl_down,
    // alt_down, caps_on, then zero fill
    output logic [M_W-1:0] m_tdata
);
    import kbd_pkg::*;

    logic              accept;
    logic              op_scan;
    logic              op_pop;
    logic              op_clear;
    key_evt_t          evt;
    mod_flags_t        flags_next;
    logic              pop_hit;
    logic [CNT_W-1:0]  count_next;
    logic [6:0]        rd_data;

    logic              out_valid_reg;
    logic              char_valid_reg;
    logic [CNT_W-1:0]  fill_reg;
    mod_flags_t        flags_out_reg;
    logic [6:0]        char_out;
    logic [FILL_W-1:0] fill_level;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op_scan  = accept && (s_tuser == OP_SCAN);
    assign op_pop   = accept && (s_tuser == OP_POP);
    assign op_clear = accept && (s_tuser == OP_CLEAR);

    kbd_keymap u_keymap (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_en    (op_scan),
        .scan_byte  (s_tdata),
        .evt        (evt),
        .flags_next (flags_next)
    );

    kbd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .pop        (op_pop),
        .clear      (op_clear),
        .pop_hit    (pop_hit),
        .count_next (count_next),
        .rd_data    (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_valid_reg <= pop_hit;
            fill_reg       <= count_next;
            flags_out_reg  <= flags_next;
        end
    end

    // The memory read data stays put until the next pop, so it can feed the output directly.
    assign char_out   = char_valid_reg ? rd_data : ASCII_NONE;
    assign fill_level = FILL_W'(fill_reg);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_W'({flags_out_reg.caps, flags_out_reg.alt, flags_out_reg.ctrl,
                              flags_out_reg.shift, fill_level, (fill_reg != '0),
                              char_valid_reg, char_out});

endmodule
